// File: sv/quintic_point_to_point_trajectory_macros.svh
// ----------------------------------------------------------------------------
// Quintic trajectory assertion macros
// Concurrent check helpers for the trajectory generator, compiled out for
// synthesis. They sample on clk and are disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef QUINTIC_POINT_TO_POINT_TRAJECTORY_MACROS_SVH
`define QUINTIC_POINT_TO_POINT_TRAJECTORY_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define QPTT_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("qptt: same-cycle check failed");

// Next-cycle implication.
`define QPTT_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("qptt: next-cycle check failed");

`else

`define QPTT_ASSERT_IMP(label, ante, cons)
`define QPTT_ASSERT_NXT(label, ante, cons)

`endif

`endif

// File: sv/qptt_pkg.sv
// ----------------------------------------------------------------------------
// Quintic trajectory package
// Field widths, workspace limits, register indexes and the microcode ROM.
// ----------------------------------------------------------------------------
package qptt_pkg;

	localparam int POS_W      = 22;
	localparam int DUR_W      = 27;
	localparam int STEP_W     = 16;
	localparam int ELAPSED_W  = 32;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 27;
	localparam int PC_W       = 5;

	localparam logic [DUR_W-1:0] DUR_RESET = 27'd5000000;

	localparam logic signed [POS_W-1:0] XY_LIMIT_P = 22'sd855000;
	localparam logic signed [POS_W-1:0] XY_LIMIT_N = -22'sd855000;
	localparam logic signed [POS_W-1:0] Z_HIGH     = 22'sd1000000;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_START_X  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_START_Y  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_START_Z  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_GOAL_X   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_GOAL_Y   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_GOAL_Z   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_DURATION = 3'd6;

	// Microcode addresses that are jump targets or checked.
	localparam logic [PC_W-1:0] PC_WAIT  = 5'd0;
	localparam logic [PC_W-1:0] PC_CHECK = 5'd1;
	localparam logic [PC_W-1:0] PC_DIV   = 5'd2;
	localparam logic [PC_W-1:0] PC_BLEND = 5'd12;
	localparam logic [PC_W-1:0] PC_OUT   = 5'd18;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_WAIT,
		OP_CHECK,
		OP_DIV,
		OP_MUL_P,
		OP_POW,
		OP_POLY,
		OP_MUL_A,
		OP_RND,
		OP_OUT
	} op_t;

	typedef enum logic [1:0] {
		AXIS_X,
		AXIS_Y,
		AXIS_Z
	} axis_t;

	typedef enum logic [1:0] {
		LAT_NONE,
		LAT_T3,
		LAT_T4
	} latch_t;

	typedef enum logic [1:0] {
		COND_NONE,
		COND_ALWAYS,
		COND_DONE,
		COND_DIV_MORE
	} cond_t;

	typedef struct packed {
		op_t             op;
		axis_t           axis;
		latch_t          lat;
		cond_t           cond;
		logic [PC_W-1:0] target;
	} ctrl_word_t;

	function automatic ctrl_word_t ucode_rom(input logic [PC_W-1:0] pc);
		ctrl_word_t w;
		w = '{op: OP_NOP, axis: AXIS_X, lat: LAT_NONE, cond: COND_ALWAYS, target: PC_WAIT};
		case (pc)
			5'd0:  w = '{OP_WAIT,  AXIS_X, LAT_NONE, COND_NONE,     PC_WAIT};
			5'd1:  w = '{OP_CHECK, AXIS_X, LAT_NONE, COND_DONE,     PC_BLEND};
			5'd2:  w = '{OP_DIV,   AXIS_X, LAT_NONE, COND_DIV_MORE, PC_DIV};
			5'd3:  w = '{OP_MUL_P, AXIS_X, LAT_NONE, COND_NONE,     PC_WAIT};
			5'd4:  w = '{OP_POW,   AXIS_X, LAT_NONE, COND_NONE,     PC_WAIT};
			5'd5:  w = '{OP_MUL_P, AXIS_X, LAT_NONE, COND_NONE,     PC_WAIT};
			5'd6:  w = '{OP_POW,   AXIS_X, LAT_T3,   COND_NONE,     PC_WAIT};
			5'd7:  w = '{OP_MUL_P, AXIS_X, LAT_NONE, COND_NONE,     PC_WAIT};
			5'd8:  w = '{OP_POW,   AXIS_X, LAT_T4,   COND_NONE,     PC_WAIT};
			5'd9:  w = '{OP_MUL_P, AXIS_X, LAT_NONE, COND_NONE,     PC_WAIT};
			5'd10: w = '{OP_POW,   AXIS_X, LAT_NONE, COND_NONE,     PC_WAIT};
			5'd11: w = '{OP_POLY,  AXIS_X, LAT_NONE, COND_NONE,     PC_WAIT};
			5'd12: w = '{OP_MUL_A, AXIS_X, LAT_NONE, COND_NONE,     PC_WAIT};
			5'd13: w = '{OP_RND,   AXIS_X, LAT_NONE, COND_NONE,     PC_WAIT};
			5'd14: w = '{OP_MUL_A, AXIS_Y, LAT_NONE, COND_NONE,     PC_WAIT};
			5'd15: w = '{OP_RND,   AXIS_Y, LAT_NONE, COND_NONE,     PC_WAIT};
			5'd16: w = '{OP_MUL_A, AXIS_Z, LAT_NONE, COND_NONE,     PC_WAIT};
			5'd17: w = '{OP_RND,   AXIS_Z, LAT_NONE, COND_NONE,     PC_WAIT};
			5'd18: w = '{OP_OUT,   AXIS_X, LAT_NONE, COND_ALWAYS,   PC_WAIT};
			default: w = '{OP_NOP, AXIS_X, LAT_NONE, COND_ALWAYS,   PC_WAIT};
		endcase
		return w;
	endfunction

endpackage

// File: sv/quintic_point_to_point_trajectory.sv
// ----------------------------------------------------------------------------
// Quintic point-to-point trajectory generator
// Minimum-jerk blend from a start to a goal point on three axes, driven by
// a microcoded sequencer around one shared multiplier and a radix-2 divider.
// ----------------------------------------------------------------------------
// Usage:
// Each input transaction on in_valid/in_ready is one control tick carrying
// step_us, the time since the previous tick. Every tick yields exactly one
// output transaction on out_valid/out_ready with the commanded x, y and z,
// the accumulated time, the motion-done flag and the workspace error flag.
// While the move is in progress a tick runs the check step, the bit-serial
// tau divider (one quotient bit per cycle), the single multiplier that forms
// tau^2..tau^5, the polynomial step, the three axis blends in turn and the
// output step; once the move is finished the check step jumps straight to
// the blends. The next tick can be accepted in the cycle after the result
// is handed to the output register.
// Reset clears the elapsed time, the output valid flag and the sequencer,
// and loads the register reset values (duration 5 s, positions zero).
// When the receiver stalls, the result waits in the output register while
// the next tick is already accepted and worked on; the sequencer then holds
// at its output step until the register is free.
// Configuration writes are taken at any time but are only meant while idle;
// every write to a listed register clears the elapsed time.
// ----------------------------------------------------------------------------
`include "quintic_point_to_point_trajectory_macros.svh"

module quintic_point_to_point_trajectory #(
	parameter int FRAC_BITS = 24
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    cfg_we,
	input  logic [qptt_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  logic [qptt_pkg::CFG_DATA_W-1:0]         cfg_data,
	input  logic                                    in_valid,
	output logic                                    in_ready,
	input  logic [qptt_pkg::STEP_W-1:0]             step_us,
	output logic                                    out_valid,
	input  logic                                    out_ready,
	output logic signed [qptt_pkg::POS_W-1:0]       pos_x_um,
	output logic signed [qptt_pkg::POS_W-1:0]       pos_y_um,
	output logic signed [qptt_pkg::POS_W-1:0]       pos_z_um,
	output logic [qptt_pkg::ELAPSED_W-1:0]          elapsed_out_us,
	output logic                                    motion_done,
	output logic                                    out_of_workspace
);
	import qptt_pkg::*;

	// Widths of the shared arithmetic.
	localparam int F      = FRAC_BITS;
	localparam int DIFF_W = POS_W + 1;
	localparam int AW     = F + 2;
	localparam int BW     = ((F > DIFF_W) ? F : DIFF_W) + 1;
	localparam int PW     = AW + BW;
	localparam int SW     = F + 5;
	localparam int QW     = POS_W + 2;
	localparam int CNT_W  = $clog2(F + 1);

	localparam logic [F:0]              ONE   = {1'b1, {F{1'b0}}};
	localparam logic signed [SW-1:0]    ONE_S = SW'(ONE);
	localparam logic [PW-1:0]           HALF  = PW'(1) << (F - 1);

	// Configuration registers.
	logic signed [POS_W-1:0] start_x_q, start_y_q, start_z_q;
	logic signed [POS_W-1:0] goal_x_q, goal_y_q, goal_z_q;
	logic [DUR_W-1:0]        dur_q;

	// Sequencer.
	logic [PC_W-1:0] pc_q, pc_d;
	ctrl_word_t      cw;
	logic            hold;
	logic            take;
	logic            slot_free;
	logic            in_acc;
	logic            out_load;

	// Datapath registers.
	logic [ELAPSED_W-1:0]    acc_q;
	logic [DUR_W-1:0]        rem_q;
	logic [CNT_W-1:0]        cnt_q;
	logic [F-1:0]            t_q, pw_q, t3_q, t4_q;
	logic [F:0]              s_q;
	logic signed [PW-1:0]    m_q;
	logic                    done_q;
	logic signed [POS_W-1:0] res_x_q, res_y_q, res_z_q;
	logic                    out_valid_q;

	// Combinational datapath.
	logic [ELAPSED_W:0]      acc_sum;
	logic [ELAPSED_W-1:0]    acc_sat;
	logic                    elapsed_ge;
	logic [DUR_W:0]          rem2;
	logic                    div_ge;
	logic [DUR_W-1:0]        rem_next;
	logic signed [POS_W-1:0] st_sel, gl_sel;
	logic signed [DIFF_W-1:0] diff;
	logic signed [AW-1:0]    mul_a;
	logic signed [BW-1:0]    mul_b;
	logic signed [PW-1:0]    prod;
	logic [F-1:0]            pow_next;
	logic signed [SW-1:0]    e3, e4, e5, poly;
	logic [F:0]              s_clamp;
	logic                    neg;
	logic [PW-1:0]           mag, rnd;
	logic [QW-1:0]           q_mag;
	logic signed [QW-1:0]    q_s, pos_full;
	logic signed [POS_W-1:0] res_val;
	logic                    outside;

	// ------------------------------------------------------------------
	// Sequencer: the ROM word for the current step drives the datapath.
	// Waiting for an input or for a free output slot holds the step.
	// ------------------------------------------------------------------
	assign cw        = ucode_rom(pc_q);
	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (cw.op == OP_WAIT);
	assign in_acc    = in_valid && in_ready;

	always_comb begin
		case (cw.op)
			OP_WAIT: hold = !in_valid;
			OP_OUT:  hold = !slot_free;
			default: hold = 1'b0;
		endcase
		case (cw.cond)
			COND_NONE:     take = 1'b0;
			COND_ALWAYS:   take = 1'b1;
			COND_DONE:     take = elapsed_ge;
			COND_DIV_MORE: take = (cnt_q != CNT_W'(1));
			default:       take = 1'b0;
		endcase
		if (hold) begin
			pc_d = pc_q;
		end else if (take) begin
			pc_d = cw.target;
		end else begin
			pc_d = pc_q + PC_W'(1);
		end
	end

	assign out_load = (cw.op == OP_OUT) && slot_free;

	// ------------------------------------------------------------------
	// Time accumulation, saturating at the top of the 32-bit range.
	// ------------------------------------------------------------------
	assign acc_sum    = {1'b0, acc_q} + (ELAPSED_W + 1)'(step_us);
	assign acc_sat    = acc_sum[ELAPSED_W] ? '1 : acc_sum[ELAPSED_W-1:0];
	assign elapsed_ge = (acc_q >= ELAPSED_W'(dur_q));

	// One quotient bit of tau = elapsed / duration per cycle. The remainder
	// stays below the duration throughout the division.
	assign rem2     = {rem_q, 1'b0};
	assign div_ge   = (rem2 >= (DUR_W + 1)'(dur_q));
	assign rem_next = div_ge ? DUR_W'(rem2 - (DUR_W + 1)'(dur_q)) : rem2[DUR_W-1:0];

	// Axis selection for the blend steps.
	always_comb begin
		case (cw.axis)
			AXIS_X: begin
				st_sel = start_x_q;
				gl_sel = goal_x_q;
			end
			AXIS_Y: begin
				st_sel = start_y_q;
				gl_sel = goal_y_q;
			end
			AXIS_Z: begin
				st_sel = start_z_q;
				gl_sel = goal_z_q;
			end
			default: begin
				st_sel = start_x_q;
				gl_sel = goal_x_q;
			end
		endcase
	end

	assign diff = DIFF_W'(gl_sel) - DIFF_W'(st_sel);

	// Shared multiplier: powers of tau, or the blend factor times the span.
	always_comb begin
		if (cw.op == OP_MUL_A) begin
			mul_a = $signed({1'b0, s_q});
			mul_b = BW'(diff);
		end else begin
			mul_a = $signed({2'b00, pw_q});
			mul_b = $signed(BW'(t_q));
		end
	end

	assign prod     = mul_a * mul_b;
	assign pow_next = m_q[2*F-1:F];

	// s = 10 t3 - 15 t4 + 6 t5, clamped to [0, 1].
	assign e3   = $signed(SW'(t3_q));
	assign e4   = $signed(SW'(t4_q));
	assign e5   = $signed(SW'(pw_q));
	assign poly = (e3 <<< 3) + (e3 <<< 1) - (e4 <<< 4) + e4 + (e5 <<< 2) + (e5 <<< 1);

	always_comb begin
		if (poly[SW-1]) begin
			s_clamp = '0;
		end else if (poly > ONE_S) begin
			s_clamp = ONE;
		end else begin
			s_clamp = poly[F:0];
		end
	end

	// Divide the product by one, rounding half away from zero.
	assign neg      = m_q[PW-1];
	assign mag      = neg ? PW'(-m_q) : PW'(m_q);
	assign rnd      = mag + HALF;
	assign q_mag    = rnd[F +: QW];
	assign q_s      = neg ? -$signed(q_mag) : $signed(q_mag);
	assign pos_full = QW'(st_sel) + q_s;

	// A goal outside the workspace box freezes every axis at its start.
	assign outside = (goal_x_q < XY_LIMIT_N) || (goal_x_q > XY_LIMIT_P) ||
		(goal_y_q < XY_LIMIT_N) || (goal_y_q > XY_LIMIT_P) ||
		goal_z_q[POS_W-1] || (goal_z_q > Z_HIGH);

	assign res_val = outside ? st_sel : pos_full[POS_W-1:0];

	// ------------------------------------------------------------------
	// Control state and configuration.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q        <= PC_WAIT;
			acc_q       <= '0;
			out_valid_q <= 1'b0;
			start_x_q   <= '0;
			start_y_q   <= '0;
			start_z_q   <= '0;
			goal_x_q    <= '0;
			goal_y_q    <= '0;
			goal_z_q    <= '0;
			dur_q       <= DUR_RESET;
		end else begin
			pc_q <= pc_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_we && (cfg_index <= REG_DURATION)) begin
				acc_q <= '0;
			end else if (in_acc) begin
				acc_q <= acc_sat;
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_START_X:  start_x_q <= cfg_data[POS_W-1:0];
					REG_START_Y:  start_y_q <= cfg_data[POS_W-1:0];
					REG_START_Z:  start_z_q <= cfg_data[POS_W-1:0];
					REG_GOAL_X:   goal_x_q  <= cfg_data[POS_W-1:0];
					REG_GOAL_Y:   goal_y_q  <= cfg_data[POS_W-1:0];
					REG_GOAL_Z:   goal_z_q  <= cfg_data[POS_W-1:0];
					REG_DURATION: dur_q     <= cfg_data[DUR_W-1:0];
					default: ;
				endcase
			end
		end
	end

	// ------------------------------------------------------------------
	// Datapath registers, written as the current microcode step directs.
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		case (cw.op)
			OP_CHECK: begin
				done_q <= elapsed_ge;
				rem_q  <= acc_q[DUR_W-1:0];
				cnt_q  <= CNT_W'(F);
				s_q    <= ONE;
			end
			OP_DIV: begin
				rem_q <= rem_next;
				cnt_q <= cnt_q - CNT_W'(1);
				t_q   <= {t_q[F-2:0], div_ge};
				pw_q  <= {t_q[F-2:0], div_ge};
			end
			OP_MUL_P, OP_MUL_A: begin
				m_q <= prod;
			end
			OP_POW: begin
				pw_q <= pow_next;
				if (cw.lat == LAT_T3) begin
					t3_q <= pow_next;
				end
				if (cw.lat == LAT_T4) begin
					t4_q <= pow_next;
				end
			end
			OP_POLY: begin
				s_q <= s_clamp;
			end
			OP_RND: begin
				case (cw.axis)
					AXIS_X:  res_x_q <= res_val;
					AXIS_Y:  res_y_q <= res_val;
					AXIS_Z:  res_z_q <= res_val;
					default: res_x_q <= res_val;
				endcase
			end
			default: ;
		endcase
		if (out_load) begin
			pos_x_um         <= res_x_q;
			pos_y_um         <= res_y_q;
			pos_z_um         <= res_z_q;
			elapsed_out_us   <= acc_q;
			motion_done      <= done_q;
			out_of_workspace <= outside;
		end
	end

	assign out_valid = out_valid_q;

	// ------------------------------------------------------------------
	// Checks.
	// ------------------------------------------------------------------
	`QPTT_ASSERT_NXT(a_tick_starts, in_valid && in_ready, pc_q == PC_CHECK)
	`QPTT_ASSERT_NXT(a_cfg_clears, cfg_we && (cfg_index <= REG_DURATION), acc_q == '0)
	`QPTT_ASSERT_IMP(a_div_rem, cw.op == OP_DIV, rem_q < dur_q)
	`QPTT_ASSERT_IMP(a_done_full, (pc_q >= PC_BLEND) && (pc_q <= PC_OUT) && done_q, s_q == ONE)

endmodule

// File: verif/tb.sv
// ----------------------------------------------------------------------------
// Testbench for the quintic point-to-point trajectory generator
// Drives control ticks and register writes into the block, predicts every
// commanded pose with an independent fixed-point model of the minimum-jerk
// blend, and checks each output transaction field by field. Directed cases
// cover reset values, the motion profile, the workspace box, duration
// extremes and writes to an unlisted index. Random moves follow, with
// random gaps on the sender and random stalls on the receiver.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
	import qptt_pkg::*;

	localparam int FRAC_BITS = 24;
	localparam longint ONE = longint'(1) << FRAC_BITS;
	// Tick length while the move is in progress, in clock cycles.
	localparam int TICK_CYCLES = FRAC_BITS + 18;
	localparam int MAX_REPORTS = 10;
	localparam int RANDOM_TICKS = 630;
	// Index 7 lies past the last listed register; writes there are ignored.
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

	typedef struct packed {
		logic signed [POS_W-1:0] x;
		logic signed [POS_W-1:0] y;
		logic signed [POS_W-1:0] z;
		logic [ELAPSED_W-1:0]    elapsed;
		logic                    done;
		logic                    outside;
	} commanded_pose_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic in_valid;
	logic in_ready;
	logic [STEP_W-1:0] step_us;
	logic out_valid;
	logic out_ready;
	logic signed [POS_W-1:0] pos_x_um;
	logic signed [POS_W-1:0] pos_y_um;
	logic signed [POS_W-1:0] pos_z_um;
	logic [ELAPSED_W-1:0] elapsed_out_us;
	logic motion_done;
	logic out_of_workspace;

	// Shadow copy of the block's registers and time accumulator.
	logic signed [POS_W-1:0] move_start [3];
	logic signed [POS_W-1:0] move_goal [3];
	logic [DUR_W-1:0] move_dur;
	logic [ELAPSED_W-1:0] elapsed_us;

	commanded_pose_t pending_poses [$];
	int unsigned fault_count = 0;
	int unsigned results_checked = 0;
	bit sender_gaps = 1'b1;
	bit receiver_stalls = 1'b1;

	quintic_point_to_point_trajectory #(
		.FRAC_BITS(FRAC_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.step_us(step_us),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.pos_x_um(pos_x_um),
		.pos_y_um(pos_y_um),
		.pos_z_um(pos_z_um),
		.elapsed_out_us(elapsed_out_us),
		.motion_done(motion_done),
		.out_of_workspace(out_of_workspace)
	);

	always #5 clk = ~clk;

	// Advances the shadow accumulator by one tick and returns the pose that
	// the block must command for it.
	function automatic commanded_pose_t plan_tick(input logic [STEP_W-1:0] step);
		commanded_pose_t pose;
		logic [ELAPSED_W:0] sum;
		longint unsigned span, tau, tau2, tau3, tau4, tau5;
		longint blend_s, travel, rounded;
		longint axis_pos [3];
		logic finished, outside;
		// The step is added first, and the sum sticks at the 32-bit maximum.
		sum = elapsed_us + step;
		elapsed_us = sum[ELAPSED_W] ? '1 : sum[ELAPSED_W-1:0];
		// With a zero duration this is true at once.
		finished = (elapsed_us >= move_dur);
		if (finished) begin
			blend_s = ONE;
		end else begin
			span = elapsed_us;
			tau = (span << FRAC_BITS) / move_dur;
			// Each power is truncated to FRAC_BITS fraction bits before the next.
			tau2 = (tau * tau) >> FRAC_BITS;
			tau3 = (tau2 * tau) >> FRAC_BITS;
			tau4 = (tau3 * tau) >> FRAC_BITS;
			tau5 = (tau4 * tau) >> FRAC_BITS;
			blend_s = 10 * longint'(tau3) - 15 * longint'(tau4) + 6 * longint'(tau5);
			if (blend_s < 0)
				blend_s = 0;
			if (blend_s > ONE)
				blend_s = ONE;
		end
		// The workspace box is inclusive on every bound.
		outside = move_goal[0] < XY_LIMIT_N || move_goal[0] > XY_LIMIT_P ||
			move_goal[1] < XY_LIMIT_N || move_goal[1] > XY_LIMIT_P ||
			move_goal[2] < 0 || move_goal[2] > Z_HIGH;
		for (int k = 0; k < 3; k++) begin
			if (outside) begin
				axis_pos[k] = move_start[k];
			end else begin
				travel = blend_s * (longint'(move_goal[k]) - longint'(move_start[k]));
				// Round to nearest, ties away from zero.
				if (travel >= 0)
					rounded = (travel + ONE / 2) / ONE;
				else
					rounded = (travel - ONE / 2) / ONE;
				axis_pos[k] = longint'(move_start[k]) + rounded;
			end
		end
		pose.x = axis_pos[0][POS_W-1:0];
		pose.y = axis_pos[1][POS_W-1:0];
		pose.z = axis_pos[2][POS_W-1:0];
		pose.elapsed = elapsed_us;
		pose.done = finished;
		pose.outside = outside;
		return pose;
	endfunction

	// Writes one register at the next rising edge and mirrors the write in the
	// shadow copy. The write enable is left high so that writes can follow
	// back to back; the caller lowers it after the last one.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		case (idx)
			REG_START_X, REG_START_Y, REG_START_Z: begin
				move_start[idx - REG_START_X] = data[POS_W-1:0];
				elapsed_us = '0;
			end
			REG_GOAL_X, REG_GOAL_Y, REG_GOAL_Z: begin
				move_goal[idx - REG_GOAL_X] = data[POS_W-1:0];
				elapsed_us = '0;
			end
			REG_DURATION: begin
				move_dur = data[DUR_W-1:0];
				elapsed_us = '0;
			end
			default: begin
			end
		endcase
	endtask

	task automatic load_move(input logic [CFG_DATA_W-1:0] sx, input logic [CFG_DATA_W-1:0] sy,
			input logic [CFG_DATA_W-1:0] sz, input logic [CFG_DATA_W-1:0] gx,
			input logic [CFG_DATA_W-1:0] gy, input logic [CFG_DATA_W-1:0] gz,
			input logic [CFG_DATA_W-1:0] dur);
		write_reg(REG_START_X, sx);
		write_reg(REG_START_Y, sy);
		write_reg(REG_START_Z, sz);
		write_reg(REG_GOAL_X, gx);
		write_reg(REG_GOAL_Y, gy);
		write_reg(REG_GOAL_Z, gz);
		write_reg(REG_DURATION, dur);
		cfg_we <= 1'b0;
	endtask

	// Sends one tick. Valid is left high after the transaction so that a tick
	// without a gap follows directly; whoever stops sending lowers it.
	task automatic send_tick(input logic [STEP_W-1:0] step);
		int unsigned gap;
		commanded_pose_t pose;
		gap = sender_gaps ? $urandom_range(0, 7) : 0;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		step_us <= step;
		do
			@(posedge clk);
		while (!in_ready);
		pose = plan_tick(step);
		pending_poses = {pending_poses, pose};
	endtask

	// Stops sending and waits until every predicted pose has come out.
	task automatic wait_for_results();
		in_valid <= 1'b0;
		while (pending_poses.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic compare_field(input string what, input logic [63:0] want,
			input logic [63:0] got);
		if (got !== want) begin
			fault_count++;
			if (fault_count <= MAX_REPORTS)
				$display("result %0d: %s expected %0d, got %0d", results_checked, what,
					$signed(want), $signed(got));
		end
	endtask

	// After reset the block must run a default move of 5 s to the origin.
	task automatic test_reset_values();
		send_tick(16'd0);
		send_tick(16'd1);
		send_tick(16'hFFFF);
		wait_for_results();
	endtask

	// Starts at the ends of the position range on x and y and ends on the corner of
	// the workspace box; ticks land on zero time, mid-move, the exact end and
	// past the end.
	task automatic test_motion_profile();
		load_move(-2097152, 2097151, 0, -855000, 855000, 1000000, 131070);
		send_tick(16'd0);
		send_tick(16'd32767);
		send_tick(16'd32768);
		send_tick(16'hFFFF);
		send_tick(16'hFFFF);
		wait_for_results();
	endtask

	// One step past each face of the box, and the lower z bound itself.
	task automatic test_workspace_bounds();
		int gx [7] = '{855001, -855001, 0, 0, 0, 0, 0};
		int gy [7] = '{0, 0, 855001, -855001, 0, 0, 0};
		int gz [7] = '{500000, 500000, 500000, 500000, -1, 1000001, 0};
		for (int i = 0; i < 7; i++) begin
			load_move(100000, -200000, 300000, gx[i], gy[i], gz[i], 100000);
			send_tick(16'd40000);
			wait_for_results();
		end
	endtask

	task automatic test_duration_extremes();
		// A zero duration finishes the move on the first tick.
		load_move(-5000, 7000, 10000, 600000, -600000, 900000, 0);
		send_tick(16'd0);
		wait_for_results();
		load_move(-5000, 7000, 10000, 600000, -600000, 900000, (1 << DUR_W) - 1);
		send_tick(16'hFFFF);
		send_tick(16'hFFFF);
		wait_for_results();
	endtask

	// A write past the register list must not clear the elapsed time.
	task automatic test_unlisted_register();
		load_move(0, 0, 0, 400000, 400000, 400000, 200000);
		send_tick(16'd50000);
		wait_for_results();
		write_reg(REG_UNUSED, '1);
		cfg_we <= 1'b0;
		send_tick(16'd50000);
		wait_for_results();
	endtask

	// Random moves: most goals lie inside the box, durations are mostly on
	// the scale of a phase's ticks so that moves run to completion, and now
	// and then the sender holds off until the pipeline is empty.
	task automatic test_random_moves();
		int unsigned sent, phase, ticks, pick;
		int pos;
		logic [CFG_DATA_W-POS_W-1:0] junk;
		logic [CFG_DATA_W-1:0] dur;
		logic [STEP_W-1:0] step;
		bit wild;
		sent = 0;
		phase = 0;
		while (sent < RANDOM_TICKS) begin
			wait_for_results();
			sender_gaps = ($urandom_range(0, 3) != 0);
			receiver_stalls = ($urandom_range(0, 3) != 0);
			wild = ($urandom_range(0, 4) == 0);
			// Upper data bits of a position write are junk that the block drops.
			for (int i = 0; i < 6; i++) begin
				junk = (CFG_DATA_W - POS_W)'($urandom);
				if (i < 3) begin
					if ($urandom_range(0, 4) == 0)
						pos = $urandom;
					else
						pos = int'($urandom_range(0, 4000000)) - 2000000;
				end else if (wild) begin
					pos = $urandom;
				end else if (i == 5) begin
					pos = $urandom_range(0, 1000000);
				end else begin
					pos = int'($urandom_range(0, 1710000)) - 855000;
				end
				write_reg(REG_START_X + CFG_IDX_W'(i), {junk, pos[POS_W-1:0]});
			end
			pick = $urandom_range(0, 19);
			case (pick)
				0: dur = '0;
				1: dur = CFG_DATA_W'(1);
				2: dur = '1;
				3: dur = CFG_DATA_W'($urandom_range(1, 1000));
				default: dur = CFG_DATA_W'($urandom_range(1, 40 * 65535));
			endcase
			write_reg(REG_DURATION, dur);
			if ($urandom_range(0, 7) == 0)
				write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
			cfg_we <= 1'b0;
			ticks = $urandom_range(10, 50);
			for (int i = 0; i < ticks; i++) begin
				// The first phase always drains once in the middle of its move.
				if (i == ticks / 2 && (phase == 0 || $urandom_range(0, 3) == 0))
					wait_for_results();
				case ($urandom_range(0, 9))
					0: step = '0;
					1: step = '1;
					default: step = STEP_W'($urandom_range(0, 65535));
				endcase
				send_tick(step);
				sent++;
			end
			phase++;
		end
		wait_for_results();
	endtask

	// Receiver: a random stall before each transaction, none when disabled.
	initial begin
		int unsigned stall;
		out_ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = receiver_stalls ? $urandom_range(0, 7) : 0;
			if (stall != 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do
				@(posedge clk);
			while (!out_valid);
		end
	end

	// Every output transaction is matched against the oldest predicted pose.
	always @(posedge clk) begin : result_check
		commanded_pose_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_poses.size() == 0) begin
				fault_count++;
				if (fault_count <= MAX_REPORTS)
					$display("result %0d: output transaction with no tick pending",
						results_checked);
			end else begin
				want = pending_poses.pop_front();
				compare_field("pos_x_um", want.x, pos_x_um);
				compare_field("pos_y_um", want.y, pos_y_um);
				compare_field("pos_z_um", want.z, pos_z_um);
				compare_field("elapsed_out_us", want.elapsed, elapsed_out_us);
				compare_field("motion_done", want.done, motion_done);
				compare_field("out_of_workspace", want.outside, out_of_workspace);
			end
			results_checked++;
		end
	end

	initial begin
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		in_valid <= 1'b0;
		step_us <= '0;
		arst_n <= 1'b0;
		// Reset values of the registers and the accumulator.
		for (int k = 0; k < 3; k++) begin
			move_start[k] = '0;
			move_goal[k] = '0;
		end
		move_dur = DUR_RESET;
		elapsed_us = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_values();
		test_motion_profile();
		test_workspace_bounds();
		test_duration_extremes();
		test_unlisted_register();
		test_random_moves();

		// Let any stray output transaction show up before the verdict.
		wait_for_results();
		repeat (2 * TICK_CYCLES) @(posedge clk);
		if (fault_count == 0 && pending_poses.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	// Watchdog: the slowest correct run stays well below this.
	initial begin
		#150_000_000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule
